// ===== src/ugrq_pkg.sv =====
package ugrq_pkg;

	// Storage geometry.
	localparam int STORE_DEPTH   = 256;
	localparam int MAX_POP_BYTES = 64;
	localparam int ADDR_W        = $clog2(STORE_DEPTH);
	localparam int SIZE_W        = $clog2(STORE_DEPTH + 1);

	// Field widths fixed by the interface.
	localparam int LEN_W    = 9;
	localparam int UC_W     = 9;
	localparam int STORED_W = UC_W + 5;
	localparam int POP_W    = $clog2(MAX_POP_BYTES + 1);
	localparam int SUM_W    = ((SIZE_W > LEN_W) ? SIZE_W : LEN_W) + 1;

	// Input word kinds.
	localparam logic [1:0] KIND_PUSH  = 2'd0;
	localparam logic [1:0] KIND_POP   = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;
	localparam logic [1:0] KIND_NOP   = 2'd3;

	// Result status codes.
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_LEN   = 3'd1;
	localparam logic [2:0] ST_FULL      = 3'd2;
	localparam logic [2:0] ST_OVERWROTE = 3'd3;
	localparam logic [2:0] ST_EMPTY     = 3'd4;

	// Configuration register indexes.
	localparam logic [1:0] CFG_QUEUE_SIZE = 2'd0;
	localparam logic [1:0] CFG_UNIT_LOG2  = 2'd1;
	localparam logic [1:0] CFG_OVERWRITE  = 2'd2;

	// Request to the position reduction unit.
	typedef struct packed {
		logic              start;
		logic [ADDR_W-1:0] dividend;
		logic [SIZE_W-1:0] divisor;
	} ugrq_mod_req_t;

	// Answer of the position reduction unit.
	typedef struct packed {
		logic              done;
		logic [ADDR_W-1:0] rem;
	} ugrq_mod_rsp_t;

endpackage

// ===== src/unit_granular_ring_queue_core.sv =====
// Channel   Direction  Handshake              Word
// input     in         in_valid / in_ready    kind, data_byte, length, first
// output    out        out_valid / out_ready  status, out_byte, byte_valid, last,
//                                             stored_units, is_empty
// config    in         cfg_write              cfg_index, cfg_data
//
// A push byte steps through the normalise, execute and byte-write states; clear, no-op and
// rejected words end after execute. A pop streams one byte per cycle from the RAM read port
// while the output is not stalled. A stored position at or above queue_size takes a pass
// through the bit-serial remainder unit on every word until that position is rewritten.
// Reset is asynchronous and clears all control state; the byte RAM is not cleared.
// A stalled output holds the sequencer; a new word is taken while a result waits.
module unit_granular_ring_queue_core import ugrq_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       kind,
	input  logic [7:0]       data_byte,
	input  logic [LEN_W-1:0] length,
	input  logic             first,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [2:0]       status,
	output logic [7:0]       out_byte,
	output logic             byte_valid,
	output logic             last,
	output logic [UC_W-1:0]  stored_units,
	output logic             is_empty,
	input  logic             cfg_write,
	input  logic [1:0]       cfg_index,
	input  logic [8:0]       cfg_data
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_NORM  = 3'd1;
	localparam logic [2:0] S_MOD   = 3'd2;
	localparam logic [2:0] S_EXEC  = 3'd3;
	localparam logic [2:0] S_PBYTE = 3'd4;
	localparam logic [2:0] S_POPRD = 3'd5;
	localparam logic [2:0] S_POPWR = 3'd6;

	localparam int P_RP = 0;
	localparam int P_WP = 1;
	localparam int P_MP = 2;

	// Configuration.
	logic [8:0] qsize_q;
	logic [2:0] ulog_q;
	logic       ow_cfg_q;

	// Queue and message state.
	logic [2:0]        state_q;
	logic [ADDR_W-1:0] read_pos_q;
	logic [ADDR_W-1:0] write_pos_q;
	logic [ADDR_W-1:0] msg_pos_q;
	logic [UC_W-1:0]   uc_q;
	logic [LEN_W-1:0]  msg_rem_q;
	logic [LEN_W-1:0]  msg_total_q;
	logic              msg_acc_q;
	logic              msg_ow_q;
	logic [ADDR_W-1:0] pop_p_q;
	logic [POP_W-1:0]  pop_left_q;
	logic [2:0]        fix_q;
	logic [1:0]        mod_sel_q;
	logic              out_valid_q;

	// Captured input word and positions reduced for it.
	logic [1:0]        kind_q;
	logic [7:0]        data_q;
	logic [LEN_W-1:0]  len_q;
	logic              first_q;
	logic [ADDR_W-1:0] pos_r_q [3];

	// Output word registers.
	logic [2:0]      status_q;
	logic [7:0]      out_byte_q;
	logic            byte_valid_q;
	logic            last_q;
	logic [UC_W-1:0] units_q;

	logic [ADDR_W-1:0] pos_a [3];
	logic [2:0]        need;
	logic [1:0]        sel;
	logic [SIZE_W-1:0] size_w;
	logic [2:0]        sh;
	logic [5:0]        mask6;
	logic [STORED_W-1:0] stored;
	logic              len_frac;
	logic              len_bad;
	logic              room_bad;
	logic [LEN_W-1:0]  drop;
	logic [SUM_W-1:0]  rp_sum;
	logic [SUM_W-1:0]  rp_wrap;
	logic [LEN_W-1:0]  n_min;
	logic [LEN_W-1:0]  n_cap;
	logic [LEN_W-1:0]  n_pop;
	logic [UC_W-1:0]   uc_drop;
	logic [UC_W-1:0]   uc_pop;
	logic [UC_W:0]     uc_sum;
	logic [UC_W-1:0]   uc_commit;
	logic [ADDR_W-1:0] np_msg;
	logic [ADDR_W-1:0] np_pop;
	logic              out_free;

	logic            emit;
	logic [2:0]      e_status;
	logic [7:0]      e_byte;
	logic            e_valid;
	logic            e_last;
	logic [UC_W-1:0] e_units;

	logic              ram_we;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic [7:0]        ram_rdata;

	ugrq_mod_req_t mod_req;
	ugrq_mod_rsp_t mod_rsp;

	// Advance a reduced position by one, wrapping at the queue size.
	function automatic logic [ADDR_W-1:0] inc_wrap(input logic [ADDR_W-1:0] p,
		input logic [SIZE_W-1:0] s);
		logic [SIZE_W-1:0] t;
		t = SIZE_W'(p) + SIZE_W'(1);
		return (t == s) ? '0 : t[ADDR_W-1:0];
	endfunction

	ugrq_ram #(
		.WIDTH(8),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(pos_r_q[P_MP]),
		.wdata(data_q),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	ugrq_mod u_mod (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (mod_req),
		.rsp   (mod_rsp)
	);

	// Effective size and unit shift, saturated to their legal ranges.
	always_comb begin
		if (qsize_q == '0) begin
			size_w = SIZE_W'(1);
		end else if (32'(qsize_q) > 32'(STORE_DEPTH)) begin
			size_w = SIZE_W'(STORE_DEPTH);
		end else begin
			size_w = SIZE_W'(qsize_q);
		end
		sh    = (ulog_q > 3'd5) ? 3'd5 : ulog_q;
		mask6 = 6'((6'd1 << sh) - 6'd1);
	end

	// Positions at or above the size that are not yet reduced need a remainder pass.
	always_comb begin
		pos_a[P_RP] = read_pos_q;
		pos_a[P_WP] = write_pos_q;
		pos_a[P_MP] = msg_pos_q;
		for (int i = 0; i < 3; i++) begin
			need[i] = !fix_q[i] && (SIZE_W'(pos_a[i]) >= size_w);
		end
		if (need[P_RP]) begin
			sel = 2'(P_RP);
		end else if (need[P_WP]) begin
			sel = 2'(P_WP);
		end else begin
			sel = 2'(P_MP);
		end
	end

	// Push checks, overwrite drop and commit arithmetic.
	always_comb begin
		stored   = STORED_W'(uc_q) << sh;
		len_frac = (len_q[5:0] & mask6) != '0;
		len_bad  = (len_q == '0) || len_frac || (32'(len_q) > 32'(size_w));
		room_bad = (32'(stored) + 32'(len_q)) > 32'(size_w);
		drop     = (32'(len_q) < 32'(stored)) ? len_q : stored[LEN_W-1:0];
		rp_sum   = SUM_W'(pos_r_q[P_RP]) + SUM_W'(drop);
		rp_wrap  = (rp_sum >= SUM_W'(size_w)) ? (rp_sum - SUM_W'(size_w)) : rp_sum;
		uc_drop  = uc_q - UC_W'(drop >> sh);
		uc_sum   = (UC_W+1)'(uc_q) + (UC_W+1)'(msg_total_q >> sh);
		uc_commit = uc_sum[UC_W] ? '1 : uc_sum[UC_W-1:0];
		np_msg   = inc_wrap(pos_r_q[P_MP], size_w);
	end

	// Pop byte count: clamp to stored bytes and the pop limit, round down to units.
	always_comb begin
		n_min  = (32'(len_q) < 32'(stored)) ? len_q : stored[LEN_W-1:0];
		n_cap  = (32'(n_min) > 32'(MAX_POP_BYTES)) ? LEN_W'(MAX_POP_BYTES) : n_min;
		n_pop  = n_cap & ~LEN_W'(mask6);
		uc_pop = uc_q - UC_W'(n_pop >> sh);
		np_pop = inc_wrap(pop_p_q, size_w);
	end

	assign out_free = !out_valid_q || out_ready;

	// Result words, RAM accesses and reduction requests per state.
	always_comb begin
		emit        = 1'b0;
		e_status    = ST_OK;
		e_byte      = '0;
		e_valid     = 1'b0;
		e_last      = 1'b1;
		e_units     = uc_q;
		ram_we      = 1'b0;
		ram_re      = 1'b0;
		ram_raddr   = pop_p_q;
		mod_req.start    = 1'b0;
		mod_req.dividend = pos_a[sel];
		mod_req.divisor  = size_w;
		unique case (state_q)
			S_NORM: begin
				mod_req.start = need != '0;
			end
			S_EXEC: begin
				if (out_free) begin
					unique case (kind_q)
						KIND_PUSH: begin
							if (first_q && len_bad) begin
								emit     = 1'b1;
								e_status = ST_BAD_LEN;
							end else if (first_q && room_bad && !ow_cfg_q) begin
								emit     = 1'b1;
								e_status = ST_FULL;
							end
						end
						KIND_POP: begin
							if (uc_q == '0) begin
								emit     = 1'b1;
								e_status = ST_EMPTY;
							end else if (len_frac) begin
								emit     = 1'b1;
								e_status = ST_BAD_LEN;
							end else if (n_pop == '0) begin
								emit     = 1'b1;
								e_status = ST_OK;
							end
						end
						KIND_CLEAR: begin
							emit    = 1'b1;
							e_units = '0;
						end
						default: begin
						end
					endcase
				end
			end
			S_PBYTE: begin
				if (out_free) begin
					ram_we = 1'b1;
					if (msg_rem_q == LEN_W'(1)) begin
						emit     = 1'b1;
						e_status = msg_ow_q ? ST_OVERWROTE : ST_OK;
						e_units  = uc_commit;
					end
				end
			end
			S_POPRD: begin
				ram_re = 1'b1;
			end
			S_POPWR: begin
				if (out_free) begin
					emit    = 1'b1;
					e_byte  = ram_rdata;
					e_valid = 1'b1;
					e_last  = pop_left_q == POP_W'(1);
					if (pop_left_q != POP_W'(1)) begin
						ram_re    = 1'b1;
						ram_raddr = np_pop;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Sequencer, queue state and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qsize_q     <= 9'd256;
			ulog_q      <= '0;
			ow_cfg_q    <= 1'b0;
			state_q     <= S_IDLE;
			read_pos_q  <= '0;
			write_pos_q <= '0;
			msg_pos_q   <= '0;
			uc_q        <= '0;
			msg_rem_q   <= '0;
			msg_total_q <= '0;
			msg_acc_q   <= 1'b0;
			msg_ow_q    <= 1'b0;
			pop_p_q     <= '0;
			pop_left_q  <= '0;
			fix_q       <= '0;
			mod_sel_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					CFG_QUEUE_SIZE: qsize_q  <= cfg_data;
					CFG_UNIT_LOG2:  ulog_q   <= cfg_data[2:0];
					CFG_OVERWRITE:  ow_cfg_q <= cfg_data[0];
					default: begin
					end
				endcase
			end

			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						fix_q   <= '0;
						state_q <= S_NORM;
					end
				end
				S_NORM: begin
					fix_q <= fix_q | ~need;
					if (need != '0) begin
						mod_sel_q <= sel;
						state_q   <= S_MOD;
					end else begin
						state_q <= S_EXEC;
					end
				end
				S_MOD: begin
					if (mod_rsp.done) begin
						fix_q[mod_sel_q] <= 1'b1;
						state_q          <= S_NORM;
					end
				end
				S_EXEC: begin
					if (out_free) begin
						unique case (kind_q)
							KIND_PUSH: begin
								if (first_q) begin
									if (len_bad || (room_bad && !ow_cfg_q)) begin
										msg_rem_q <= '0;
										msg_acc_q <= 1'b0;
										msg_ow_q  <= 1'b0;
										state_q   <= S_IDLE;
									end else begin
										if (room_bad) begin
											read_pos_q <= rp_wrap[ADDR_W-1:0];
											uc_q       <= uc_drop;
										end
										msg_ow_q    <= room_bad;
										msg_acc_q   <= 1'b1;
										msg_rem_q   <= len_q;
										msg_total_q <= len_q;
										msg_pos_q   <= pos_r_q[P_WP];
										state_q     <= S_PBYTE;
									end
								end else if (msg_acc_q && msg_rem_q != '0) begin
									state_q <= S_PBYTE;
								end else begin
									state_q <= S_IDLE;
								end
							end
							KIND_POP: begin
								if (uc_q != '0 && !len_frac && n_pop != '0) begin
									uc_q       <= uc_pop;
									pop_p_q    <= pos_r_q[P_RP];
									pop_left_q <= n_pop[POP_W-1:0];
									state_q    <= S_POPRD;
								end else begin
									state_q <= S_IDLE;
								end
							end
							KIND_CLEAR: begin
								read_pos_q  <= '0;
								write_pos_q <= '0;
								msg_pos_q   <= '0;
								uc_q        <= '0;
								msg_rem_q   <= '0;
								msg_total_q <= '0;
								msg_acc_q   <= 1'b0;
								msg_ow_q    <= 1'b0;
								state_q     <= S_IDLE;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_PBYTE: begin
					if (out_free) begin
						msg_pos_q <= np_msg;
						msg_rem_q <= msg_rem_q - LEN_W'(1);
						if (msg_rem_q == LEN_W'(1)) begin
							uc_q        <= uc_commit;
							write_pos_q <= np_msg;
							msg_acc_q   <= 1'b0;
						end
						state_q <= S_IDLE;
					end
				end
				S_POPRD: begin
					state_q <= S_POPWR;
				end
				S_POPWR: begin
					if (out_free) begin
						pop_p_q    <= np_pop;
						pop_left_q <= pop_left_q - POP_W'(1);
						if (pop_left_q == POP_W'(1)) begin
							read_pos_q <= np_pop;
							state_q    <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Captured word, reduced positions and output word.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			kind_q  <= kind;
			data_q  <= data_byte;
			len_q   <= length;
			first_q <= first;
		end
		if (state_q == S_NORM) begin
			for (int i = 0; i < 3; i++) begin
				if (!fix_q[i] && !need[i]) begin
					pos_r_q[i] <= pos_a[i];
				end
			end
		end
		if (state_q == S_MOD && mod_rsp.done) begin
			pos_r_q[mod_sel_q] <= mod_rsp.rem;
		end
		if (state_q == S_EXEC && out_free && kind_q == KIND_PUSH && first_q) begin
			pos_r_q[P_MP] <= pos_r_q[P_WP];
		end
		if (emit) begin
			status_q     <= e_status;
			out_byte_q   <= e_byte;
			byte_valid_q <= e_valid;
			last_q       <= e_last;
			units_q      <= e_units;
		end
	end

	assign in_ready     = state_q == S_IDLE;
	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign out_byte     = out_byte_q;
	assign byte_valid   = byte_valid_q;
	assign last         = last_q;
	assign stored_units = units_q;
	assign is_empty     = units_q == '0;

endmodule

// ===== src/ugrq_ram.sv =====
module ugrq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/ugrq_mod.sv =====
module ugrq_mod import ugrq_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  ugrq_mod_req_t req,
	output ugrq_mod_rsp_t rsp
);

	localparam int CNT_W = $clog2(ADDR_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SIZE_W-1:0] rem_q;
	logic [ADDR_W-1:0] x_q;
	logic [SIZE_W-1:0] d_q;
	logic [SIZE_W:0]   trial;
	logic [SIZE_W:0]   rem_nx;

	// Restoring remainder step: bring in one dividend bit, subtract if it fits.
	always_comb begin
		trial  = {rem_q, x_q[ADDR_W-1]};
		rem_nx = (trial >= {1'b0, d_q}) ? (trial - {1'b0, d_q}) : trial;
	end

	// Step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(ADDR_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Operand and partial remainder registers.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			x_q   <= req.dividend;
			d_q   <= req.divisor;
		end else if (busy_q) begin
			rem_q <= rem_nx[SIZE_W-1:0];
			x_q   <= {x_q[ADDR_W-2:0], 1'b0};
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q[ADDR_W-1:0];

endmodule

// ===== verif/unit_granular_ring_queue_core_tb.sv =====
`timescale 1ns / 100ps

module unit_granular_ring_queue_core_tb;
	import ugrq_pkg::*;

	localparam int HALF_PERIOD   = 10;
	localparam int SETTLE_CYCLES = 64;
	localparam int LONG_HOLD     = 300;
	localparam int RANDOM_WORDS  = 48;
	localparam int PHASE_WORDS   = 8;

	// One input word and one result word.
	typedef struct {
		logic [1:0]       kind;
		logic [7:0]       data;
		logic [LEN_W-1:0] len;
		logic             first;
	} word_t;

	typedef struct {
		logic [2:0]      status;
		logic [7:0]      data;
		logic            valid;
		logic            last;
		logic [UC_W-1:0] units;
		logic            empty;
	} result_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [1:0]       kind = KIND_NOP;
	logic [7:0]       data_byte = '0;
	logic [LEN_W-1:0] length = '0;
	logic             first = 1'b0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [2:0]       status;
	logic [7:0]       out_byte;
	logic             byte_valid;
	logic             last;
	logic [UC_W-1:0]  stored_units;
	logic             is_empty;
	logic             cfg_write = 1'b0;
	logic [1:0]       cfg_index = '0;
	logic [8:0]       cfg_data = '0;

	unit_granular_ring_queue_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.data_byte(data_byte),
		.length(length),
		.first(first),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.out_byte(out_byte),
		.byte_valid(byte_valid),
		.last(last),
		.stored_units(stored_units),
		.is_empty(is_empty),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Words waiting to be offered and results waiting to arrive.
	word_t   pending_words[$];
	result_t expected_results[$];
	int      error_count = 0;
	int      words_queued = 0;
	int      random_done = 0;
	bit      in_idle_on = 1'b0;
	bit      out_idle_on = 1'b0;
	int      hold_requests = 0;

	// Shadow of the ring: storage, positions, open message and registers.
	logic [7:0]  ring_mem [STORE_DEPTH];
	bit          ring_written [STORE_DEPTH];
	int          written_total = 0;
	int unsigned rd_pos = 0, wr_pos = 0, held_units = 0;
	int unsigned msg_pos = 0, msg_left = 0, msg_total = 0;
	bit          msg_open = 1'b0, msg_dropped = 1'b0;
	int unsigned cfg_qsize = 256, cfg_ulog2 = 0;
	bit          cfg_ovw = 1'b0;

	// Clock.
	initial begin
		forever #HALF_PERIOD clk = ~clk;
	end

	function automatic int unsigned clamp_size(int unsigned q);
		if (q < 1) return 1;
		if (q > STORE_DEPTH) return STORE_DEPTH;
		return q;
	endfunction

	function automatic int unsigned clamp_shift(int unsigned u);
		return (u > 5) ? 5 : u;
	endfunction

	function automatic void expect_result(logic [2:0] st, logic [7:0] b, logic v, logic l);
		result_t r;
		r.status = st;
		r.data   = b;
		r.valid  = v;
		r.last   = l;
		r.units  = held_units[UC_W-1:0];
		r.empty  = (held_units == 0);
		expected_results.push_back(r);
	endfunction

	// Advance the ring shadow by one accepted word and queue its results.
	function automatic void ring_queue_step(word_t w);
		int unsigned sz, sh, unit, lenv, held, drop, n, p, sum;
		sz   = clamp_size(cfg_qsize);
		sh   = clamp_shift(cfg_ulog2);
		unit = 1 << sh;
		lenv = 32'(w.len);
		case (w.kind)
		KIND_PUSH: begin
			// The first byte checks the length and makes room or refuses.
			if (w.first) begin
				held = held_units << sh;
				msg_left = 0;
				msg_open = 1'b0;
				msg_dropped = 1'b0;
				if (lenv == 0 || (lenv & (unit - 1)) != 0 || lenv > sz) begin
					expect_result(ST_BAD_LEN, 8'd0, 1'b0, 1'b1);
					return;
				end
				if (held + lenv > sz) begin
					if (!cfg_ovw) begin
						expect_result(ST_FULL, 8'd0, 1'b0, 1'b1);
						return;
					end
					drop = (lenv < held) ? lenv : held;
					rd_pos = (rd_pos % sz + drop) % sz;
					held_units -= drop >> sh;
					msg_dropped = 1'b1;
				end
				msg_open  = 1'b1;
				msg_left  = lenv;
				msg_total = lenv;
				msg_pos   = wr_pos % sz;
			end
			if (!msg_open || msg_left == 0) return;
			p = msg_pos % sz;
			ring_mem[p] = w.data;
			if (!ring_written[p]) begin
				ring_written[p] = 1'b1;
				written_total++;
			end
			msg_pos = (p + 1) % sz;
			msg_left--;
			// The last byte commits the message.
			if (msg_left == 0) begin
				sum = held_units + (msg_total >> sh);
				held_units = (sum > 511) ? 511 : sum;
				wr_pos = msg_pos;
				msg_open = 1'b0;
				expect_result(msg_dropped ? ST_OVERWROTE : ST_OK, 8'd0, 1'b0, 1'b1);
			end
		end
		KIND_POP: begin
			held = held_units << sh;
			if (held_units == 0) begin
				expect_result(ST_EMPTY, 8'd0, 1'b0, 1'b1);
			end else if ((lenv & (unit - 1)) != 0) begin
				expect_result(ST_BAD_LEN, 8'd0, 1'b0, 1'b1);
			end else begin
				n = (lenv < held) ? lenv : held;
				if (n > MAX_POP_BYTES) n = MAX_POP_BYTES;
				n &= ~(unit - 1);
				if (n == 0) begin
					expect_result(ST_OK, 8'd0, 1'b0, 1'b1);
				end else begin
					held_units -= n >> sh;
					p = rd_pos % sz;
					for (int i = 0; i < n; i++) begin
						expect_result(ST_OK, ring_mem[p], 1'b1, (i + 1 == n));
						p = (p + 1) % sz;
					end
					rd_pos = p;
				end
			end
		end
		KIND_CLEAR: begin
			rd_pos = 0;
			wr_pos = 0;
			held_units = 0;
			msg_pos = 0;
			msg_left = 0;
			msg_open = 1'b0;
			msg_total = 0;
			msg_dropped = 1'b0;
			expect_result(ST_OK, 8'd0, 1'b0, 1'b1);
		end
		default: ;
		endcase
	endfunction

	// A new layout is safe when every byte it can hand out has been written:
	// no open message, stored bytes fit, and they end where writing resumes.
	function automatic bit layout_ok(int unsigned q, int unsigned u);
		int unsigned sz, held, rp;
		sz   = clamp_size(q);
		held = held_units << clamp_shift(u);
		rp   = rd_pos % sz;
		if (written_total == STORE_DEPTH) return 1'b1;
		if (msg_open || held > sz || (rp + held) % sz != wr_pos % sz) return 1'b0;
		for (int i = 0; i < held; i++) begin
			if (!ring_written[(rp + i) % sz]) return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			error_count++;
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
		end
	endfunction

	// Driver: offers pending words and predicts each accepted word.
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin : word_driver
		word_t w;
		word_t taken;
		if (!arst_n) begin
			in_valid <= 1'b0;
			kind <= KIND_NOP;
			data_byte <= '0;
			length <= '0;
			first <= 1'b0;
			gap_left <= 0;
		end else begin
			if (in_valid && in_ready) begin
				taken.kind  = kind;
				taken.data  = data_byte;
				taken.len   = length;
				taken.first = first;
				ring_queue_step(taken);
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (pending_words.size() > 0) begin
					w = pending_words.pop_front();
					kind <= w.kind;
					data_byte <= w.data;
					length <= w.len;
					first <= w.first;
					in_valid <= 1'b1;
					gap_left <= in_idle_on ? $urandom_range(0, 14) : 0;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each result word and paces out_ready.
	int stall_left = 0;
	int holds_served = 0;
	always @(posedge clk or negedge arst_n) begin : result_monitor
		result_t e;
		int pause;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					error_count++;
					$display("%0t: result word, expected none, actual status %0d byte %0d last %0d",
						$time, status, out_byte, last);
				end else begin
					e = expected_results.pop_front();
					check_field("status", e.status, status);
					check_field("out_byte", e.data, out_byte);
					check_field("byte_valid", e.valid, byte_valid);
					check_field("last", e.last, last);
					check_field("stored_units", e.units, stored_units);
					check_field("is_empty", e.empty, is_empty);
				end
			end
			// A requested long hold-off takes priority over the per-word pause.
			if (holds_served != hold_requests) begin
				holds_served <= hold_requests;
				stall_left <= LONG_HOLD;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_ready <= 1'b0;
			end else if (out_valid && out_ready) begin
				pause = out_idle_on ? $urandom_range(0, 14) : 0;
				if (pause == 0) begin
					out_ready <= 1'b1;
				end else begin
					out_ready <= 1'b0;
					stall_left <= pause - 1;
				end
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic add_word(logic [1:0] k, logic [7:0] d, logic [LEN_W-1:0] n, logic f);
		word_t w;
		w.kind  = k;
		w.data  = d;
		w.len   = n;
		w.first = f;
		pending_words.push_back(w);
		words_queued++;
	endtask

	// Push message: length on the first byte, random length on the others.
	task automatic add_message(int unsigned len_field, int unsigned nbytes);
		for (int i = 0; i < nbytes; i++) begin
			add_word(KIND_PUSH, 8'($urandom_range(0, 255)),
				LEN_W'((i == 0) ? len_field : $urandom_range(0, 511)), (i == 0));
		end
	endtask

	// Wait until all words are taken and all results are in, then let the block finish.
	task automatic settle();
		do @(negedge clk);
		while (pending_words.size() != 0 || in_valid || expected_results.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [8:0] val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
		CFG_QUEUE_SIZE: cfg_qsize = 32'(val);
		CFG_UNIT_LOG2:  cfg_ulog2 = 32'(val[2:0]);
		CFG_OVERWRITE:  cfg_ovw = val[0];
		default: ;
		endcase
	endtask

	task automatic configure(int unsigned q, int unsigned u, bit o);
		// Clear first when the new layout could hand out bytes never written.
		if (!layout_ok(q, u)) begin
			add_word(KIND_CLEAR, 8'($urandom_range(0, 255)), LEN_W'($urandom_range(0, 511)),
				1'($urandom_range(0, 1)));
			settle();
		end
		write_reg(CFG_QUEUE_SIZE, q[8:0]);
		write_reg(CFG_UNIT_LOG2, u[8:0]);
		write_reg(CFG_OVERWRITE, {8'd0, o});
	endtask

	// Mostly well-formed messages and pops sized to the unit, plus noise.
	task automatic random_traffic(int count);
		int unsigned sz, unit, maxu, cap, n;
		int pick, useful, queued_start;
		useful = 0;
		while (useful < count) begin
			sz   = clamp_size(cfg_qsize);
			unit = 1 << clamp_shift(cfg_ulog2);
			maxu = sz / unit;
			cap  = 24 / unit;
			if (cap < 1) cap = 1;
			if (cap > maxu) cap = maxu;
			if ($urandom_range(0, 15) == 0) cap = maxu;
			pick = $urandom_range(0, 99);
			queued_start = words_queued;
			if (pick < 50) begin
				n = (maxu == 0) ? unit : unit * $urandom_range(1, cap);
				add_message(n, n);
			end else if (pick < 72) begin
				if ($urandom_range(0, 5) == 0) n = $urandom_range(0, 511);
				else n = unit * $urandom_range(0, 3);
				add_word(KIND_POP, 8'($urandom_range(0, 255)), LEN_W'(n),
					1'($urandom_range(0, 1)));
			end else if (pick < 77) begin
				add_word(KIND_CLEAR, 8'($urandom_range(0, 255)), LEN_W'($urandom_range(0, 511)),
					1'($urandom_range(0, 1)));
			end else if (pick < 84) begin
				add_message($urandom_range(0, 511), $urandom_range(1, 3));
			end else if (pick < 90) begin
				// Message possibly cut short; the next first byte or clear abandons it.
				n = (maxu == 0) ? unit : unit * $urandom_range(1, cap);
				add_message(n, $urandom_range(1, n));
			end else if (pick < 95) begin
				add_word(KIND_PUSH, 8'($urandom_range(0, 255)), LEN_W'($urandom_range(0, 511)),
					1'b0);
			end else begin
				add_word(KIND_NOP, 8'($urandom_range(0, 255)), LEN_W'($urandom_range(0, 511)),
					1'($urandom_range(0, 1)));
			end
			if (pick < 90) useful += words_queued - queued_start;
		end
		random_done += useful;
	endtask

	// Stimulus: directed words first, then random phases under changing layouts.
	initial begin : stimulus
		int unsigned q, u;
		bit o;
		int phase;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		configure(256, 0, 0);
		add_word(KIND_POP, 8'h00, 9'd64, 1'b0);
		add_word(KIND_PUSH, 8'h11, 9'd0, 1'b1);
		add_word(KIND_PUSH, 8'h22, 9'h1ff, 1'b1);
		add_word(KIND_PUSH, 8'h33, 9'd5, 1'b0);
		add_word(KIND_NOP, 8'hff, 9'h1ff, 1'b1);
		add_word(KIND_PUSH, 8'h00, 9'd3, 1'b1);
		add_word(KIND_PUSH, 8'hff, 9'h1ff, 1'b0);
		add_word(KIND_PUSH, 8'h5a, 9'd0, 1'b0);
		add_word(KIND_POP, 8'hff, 9'd0, 1'b1);
		// A message abandoned after two bytes by a new first byte.
		add_word(KIND_PUSH, 8'h44, 9'd4, 1'b1);
		add_word(KIND_PUSH, 8'h55, 9'd4, 1'b0);
		add_word(KIND_PUSH, 8'h81, 9'd1, 1'b1);
		add_word(KIND_POP, 8'h00, 9'h1ff, 1'b0);
		add_word(KIND_CLEAR, 8'hff, 9'h1ff, 1'b1);
		settle();

		// Four-byte units in an eight-byte ring: bad lengths, refusal, overwrite.
		configure(8, 2, 0);
		add_word(KIND_PUSH, 8'h01, 9'd6, 1'b1);
		add_word(KIND_PUSH, 8'h02, 9'd12, 1'b1);
		add_message(8, 8);
		add_message(4, 4);
		add_word(KIND_POP, 8'h00, 9'd2, 1'b0);
		settle();
		configure(8, 2, 1);
		add_message(4, 4);
		add_word(KIND_POP, 8'h00, 9'd4, 1'b0);
		add_message(4, 2);
		add_word(KIND_CLEAR, 8'h00, 9'd0, 1'b0);
		add_word(KIND_PUSH, 8'h77, 9'd0, 1'b0);
		settle();

		// A pop clamped to the largest burst.
		configure(256, 0, 0);
		add_message(66, 66);
		add_word(KIND_POP, 8'h00, 9'h1ff, 1'b1);
		add_word(KIND_POP, 8'h00, 9'd2, 1'b0);
		settle();

		phase = 0;
		while (random_done < RANDOM_WORDS) begin
			case (phase)
			0: configure(511, 7, 1);
			1: configure(1, 0, 0);
			2: configure(0, 5, 1);
			3: configure(256, 3, 0);
			default: begin
				case ($urandom_range(0, 5))
				0: q = $urandom_range(257, 511);
				1: q = $urandom_range(2, 15);
				2: q = 256;
				default: q = $urandom_range(16, 96);
				endcase
				u = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 2);
				o = 1'($urandom_range(0, 1));
				configure(q, u, o);
			end
			endcase
			in_idle_on = 1'($urandom_range(0, 1));
			out_idle_on = 1'($urandom_range(0, 1));
			// The receiver holds off while words stream back to back.
			if (phase == 0) begin
				in_idle_on = 1'b0;
				hold_requests++;
			end
			random_traffic(PHASE_WORDS);
			settle();
			phase++;
		end

		if (error_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// Watchdog.
	initial begin : watchdog
		#40_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

// ===== sim.f =====
src/ugrq_pkg.sv
src/ugrq_ram.sv
src/ugrq_mod.sv
src/unit_granular_ring_queue_core.sv
verif/unit_granular_ring_queue_core_tb.sv
